/* src/tnu_pkg.sv */
`timescale 1ns / 1ps

package tnu_pkg;

   localparam int NORMAL_LENGTH = 127;
   localparam int LEN_SQ        = NORMAL_LENGTH * NORMAL_LENGTH;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = PROD_W - 1;
   localparam int LO_W    = MAG_W / 2;
   localparam int HI_W    = MAG_W - LO_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int Q_W     = $clog2(NORMAL_LENGTH + 1);
   localparam int WIDE_W  = SUM_W + 2 * Q_W;
   localparam int OUT_W   = Q_W + 1;
   localparam int NCOMP   = 3;

   // control that travels beside each request
   typedef struct packed {
      logic             vld;
      logic             deg;
      logic [NCOMP-1:0] neg;
   } ctl_type;

endpackage

/* src/triangle_normal_unit_top.sv */
`timescale 1ns / 1ps

// Face normal of a triangle scaled to length 127, truncated toward zero.
// A request is taken in every cycle (busy stays low). Its result is on the
// rsp_ ports, marked by rsp_valid, in request order. There are fourteen
// register stages and the first loads at the accepting edge: three form the
// cross product, three square and sum it, seven run a restoring search for
// each 7-bit component magnitude (one bit per stage), and one applies the
// sign. A zero cross product gives zeros with rsp_degenerate set.

module triangle_normal_unit_top import tnu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_v0_x,
   input  logic signed [COORD_W-1:0] req_v0_y,
   input  logic signed [COORD_W-1:0] req_v0_z,
   input  logic signed [COORD_W-1:0] req_v1_x,
   input  logic signed [COORD_W-1:0] req_v1_y,
   input  logic signed [COORD_W-1:0] req_v1_z,
   input  logic signed [COORD_W-1:0] req_v2_x,
   input  logic signed [COORD_W-1:0] req_v2_y,
   input  logic signed [COORD_W-1:0] req_v2_z,
   output logic                      rsp_valid,
   output logic signed [OUT_W-1:0]   rsp_norm_x,
   output logic signed [OUT_W-1:0]   rsp_norm_y,
   output logic signed [OUT_W-1:0]   rsp_norm_z,
   output logic                      rsp_degenerate
);

   localparam int ITER = Q_W;

   ctl_type          x_ctl;
   logic [MAG_W-1:0] x_mag [NCOMP];

   assign busy = 1'b0;

   tnu_cross u_cross (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start),
      .v0_x    (req_v0_x),
      .v0_y    (req_v0_y),
      .v0_z    (req_v0_z),
      .v1_x    (req_v1_x),
      .v1_y    (req_v1_y),
      .v1_z    (req_v1_z),
      .v2_x    (req_v2_x),
      .v2_y    (req_v2_y),
      .v2_z    (req_v2_z),
      .ctl_out (x_ctl),
      .mag_out (x_mag)
   );

   // stage 4: partial products of each square
   logic [2*HI_W-1:0]      hh_ff [NCOMP];
   logic [HI_W+LO_W-1:0]   hl_ff [NCOMP];
   logic [2*LO_W-1:0]      ll_ff [NCOMP];
   ctl_type                ctl4_ff;
   // stage 5: squares
   logic [SQ_W-1:0]        sq_ff [NCOMP];
   logic [SQ_W-1:0]        sq_in [NCOMP];
   ctl_type                ctl5_ff;

   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         sq_in[c] = (SQ_W'(hh_ff[c]) << (2 * LO_W)) + (SQ_W'(hl_ff[c]) << (LO_W + 1))
                    + SQ_W'(ll_ff[c]);
      end
   end

   // search pipeline: index 0 is loaded from the squares
   logic [WIDE_W-1:0] sum_ff [ITER+1];
   logic [WIDE_W-1:0] r_ff   [NCOMP][ITER+1];
   logic [WIDE_W-1:0] p_ff   [NCOMP][ITER+1];
   logic [WIDE_W-1:0] qs_ff  [NCOMP][ITER+1];
   logic [Q_W-1:0]    q_ff   [NCOMP][ITER+1];
   ctl_type           ctl_ff [ITER+1];

   logic [WIDE_W-1:0] cand_in [NCOMP][ITER];
   logic [WIDE_W-1:0] p_in    [NCOMP][ITER];
   logic [WIDE_W-1:0] qs_in   [NCOMP][ITER];
   logic [Q_W-1:0]    q_in    [NCOMP][ITER];

   // trial t = q | bit: t^2*S = q^2*S + 2*bit*(q*S) + bit^2*S, so keep q^2*S and q*S
   always_comb begin
      for (int k = 0; k < ITER; k++) begin
         for (int c = 0; c < NCOMP; c++) begin
            cand_in[c][k] = p_ff[c][k] + (qs_ff[c][k] << (ITER - k))
                            + (sum_ff[k] << (2 * (ITER - 1 - k)));
            p_in[c][k]  = p_ff[c][k];
            qs_in[c][k] = qs_ff[c][k];
            q_in[c][k]  = q_ff[c][k];
            if (cand_in[c][k] <= r_ff[c][k]) begin
               p_in[c][k]              = cand_in[c][k];
               qs_in[c][k]             = qs_ff[c][k] + (sum_ff[k] << (ITER - 1 - k));
               q_in[c][k][ITER-1-k]    = 1'b1;
            end
         end
      end
   end

   logic signed [OUT_W-1:0] norm_in [NCOMP];
   logic signed [OUT_W-1:0] norm_ff [NCOMP];
   logic                    deg_ff;
   logic                    vld_out_ff;

   always_comb begin
      for (int c = 0; c < NCOMP; c++) begin
         if (ctl_ff[ITER].deg) begin
            norm_in[c] = '0;
         end else if (ctl_ff[ITER].neg[c]) begin
            norm_in[c] = -$signed({1'b0, q_ff[c][ITER]});
         end else begin
            norm_in[c] = $signed({1'b0, q_ff[c][ITER]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff    <= '0;
         ctl5_ff    <= '0;
         ctl_ff     <= '{default: '0};
         vld_out_ff <= 1'b0;
      end else begin
         ctl4_ff   <= x_ctl;
         ctl5_ff   <= ctl4_ff;
         ctl_ff[0] <= ctl5_ff;
         for (int k = 0; k < ITER; k++) begin
            ctl_ff[k+1] <= ctl_ff[k];
         end
         vld_out_ff <= ctl_ff[ITER].vld;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NCOMP; c++) begin
         hh_ff[c] <= x_mag[c][MAG_W-1:LO_W] * x_mag[c][MAG_W-1:LO_W];
         hl_ff[c] <= x_mag[c][MAG_W-1:LO_W] * x_mag[c][LO_W-1:0];
         ll_ff[c] <= x_mag[c][LO_W-1:0] * x_mag[c][LO_W-1:0];
         sq_ff[c] <= sq_in[c];
         r_ff[c][0]  <= WIDE_W'(sq_ff[c]) * WIDE_W'(LEN_SQ);
         p_ff[c][0]  <= '0;
         qs_ff[c][0] <= '0;
         q_ff[c][0]  <= '0;
         for (int k = 0; k < ITER; k++) begin
            r_ff[c][k+1]  <= r_ff[c][k];
            p_ff[c][k+1]  <= p_in[c][k];
            qs_ff[c][k+1] <= qs_in[c][k];
            q_ff[c][k+1]  <= q_in[c][k];
         end
         norm_ff[c] <= norm_in[c];
      end
      sum_ff[0] <= WIDE_W'(sq_ff[0]) + WIDE_W'(sq_ff[1]) + WIDE_W'(sq_ff[2]);
      for (int k = 0; k < ITER; k++) begin
         sum_ff[k+1] <= sum_ff[k];
      end
      deg_ff <= ctl_ff[ITER].deg;
   end

   assign rsp_valid      = vld_out_ff;
   assign rsp_norm_x     = norm_ff[0];
   assign rsp_norm_y     = norm_ff[1];
   assign rsp_norm_z     = norm_ff[2];
   assign rsp_degenerate = deg_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0)
      else $error("degenerate result with nonzero normal");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_x != -(2 ** Q_W) && rsp_norm_y != -(2 ** Q_W)
                    && rsp_norm_z != -(2 ** Q_W))
      else $error("normal component out of range");

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(ctl_ff[ITER].vld))
      else $error("result without a request in the search pipeline");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_norm_x != '0 || rsp_norm_y != '0 || rsp_norm_z != '0)
      else $error("nondegenerate triangle gave an all-zero normal");

endmodule

/* src/tnu_cross.sv */
`timescale 1ns / 1ps

module tnu_cross import tnu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_vld,
   input  logic signed [COORD_W-1:0] v0_x,
   input  logic signed [COORD_W-1:0] v0_y,
   input  logic signed [COORD_W-1:0] v0_z,
   input  logic signed [COORD_W-1:0] v1_x,
   input  logic signed [COORD_W-1:0] v1_y,
   input  logic signed [COORD_W-1:0] v1_z,
   input  logic signed [COORD_W-1:0] v2_x,
   input  logic signed [COORD_W-1:0] v2_y,
   input  logic signed [COORD_W-1:0] v2_z,
   output ctl_type                   ctl_out,
   output logic        [MAG_W-1:0]   mag_out [NCOMP]
);

   // stage 1: edge vectors a = v1 - v0, b = v2 - v0
   logic signed [DIFF_W-1:0] a_ff [NCOMP];
   logic signed [DIFF_W-1:0] b_ff [NCOMP];
   logic signed [DIFF_W-1:0] a_in [NCOMP];
   logic signed [DIFF_W-1:0] b_in [NCOMP];
   logic                     vld1_ff;

   // stage 2: six products
   logic signed [PROD_W-1:0] pp_ff [NCOMP];
   logic signed [PROD_W-1:0] pm_ff [NCOMP];
   logic signed [PROD_W-1:0] pp_in [NCOMP];
   logic signed [PROD_W-1:0] pm_in [NCOMP];
   logic                     vld2_ff;

   // stage 3: cross product magnitude and sign
   logic signed [CROSS_W-1:0] c_in   [NCOMP];
   logic        [CROSS_W-1:0] abs_in [NCOMP];
   logic        [MAG_W-1:0]   mag_ff [NCOMP];
   logic        [MAG_W-1:0]   mag_in [NCOMP];
   ctl_type                   ctl_ff;
   ctl_type                   ctl_in;

   always_comb begin
      a_in[0] = DIFF_W'(v1_x) - DIFF_W'(v0_x);
      a_in[1] = DIFF_W'(v1_y) - DIFF_W'(v0_y);
      a_in[2] = DIFF_W'(v1_z) - DIFF_W'(v0_z);
      b_in[0] = DIFF_W'(v2_x) - DIFF_W'(v0_x);
      b_in[1] = DIFF_W'(v2_y) - DIFF_W'(v0_y);
      b_in[2] = DIFF_W'(v2_z) - DIFF_W'(v0_z);
   end

   always_comb begin
      pp_in[0] = a_ff[1] * b_ff[2];
      pm_in[0] = a_ff[2] * b_ff[1];
      pp_in[1] = a_ff[2] * b_ff[0];
      pm_in[1] = a_ff[0] * b_ff[2];
      pp_in[2] = a_ff[0] * b_ff[1];
      pm_in[2] = a_ff[1] * b_ff[0];
   end

   always_comb begin
      ctl_in.vld = vld2_ff;
      for (int c = 0; c < NCOMP; c++) begin
         c_in[c]       = CROSS_W'(pp_ff[c]) - CROSS_W'(pm_ff[c]);
         ctl_in.neg[c] = c_in[c][CROSS_W-1];
         abs_in[c]     = c_in[c][CROSS_W-1] ? CROSS_W'(-c_in[c]) : CROSS_W'(c_in[c]);
         mag_in[c]     = abs_in[c][MAG_W-1:0];
      end
      ctl_in.deg = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         ctl_ff  <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      pm_ff  <= pm_in;
      mag_ff <= mag_in;
   end

   assign ctl_out = ctl_ff;
   assign mag_out = mag_ff;

endmodule

/* sim/triangle_normal_unit_top_tb.sv */
`timescale 1ns / 1ps

module triangle_normal_unit_top_tb;
   import tnu_pkg::*;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OUT_W-1:0]   norm_type;

   typedef struct {
      coord_type v [9];
   } tri_req_type;

   typedef struct packed {
      norm_type nx, ny, nz;
      logic     deg;
   } normal_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PIPE_DRAIN     = 40;
   localparam int RANDOM_ITEMS   = 900;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_v [9];
   logic      rsp_valid;
   norm_type  rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic      rsp_degenerate;

   normal_type normal_queue [$];
   int         failures = 0;
   int         checked = 0;
   int         degenerate_seen = 0;
   int         idle_cycles = 0;
   logic       stim_done = 1'b0;

   triangle_normal_unit_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_v0_x(req_v[0]), .req_v0_y(req_v[1]), .req_v0_z(req_v[2]),
      .req_v1_x(req_v[3]), .req_v1_y(req_v[4]), .req_v1_z(req_v[5]),
      .req_v2_x(req_v[6]), .req_v2_y(req_v[7]), .req_v2_z(req_v[8]),
      .rsp_valid(rsp_valid), .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y),
      .rsp_norm_z(rsp_norm_z), .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < 9; i++) req_v[i] = '0;
   end

   // largest q in 0..127 with q^2 * S <= 127^2 * c^2, sign of c applied
   function automatic norm_type scaled_component(logic signed [63:0] c,
                                                 logic [127:0] sum_sq);
      logic [127:0] mag, rhs;
      logic [7:0]   q, t;
      mag = (c < 0) ? -c : c;
      rhs = mag * mag * NORMAL_LENGTH * NORMAL_LENGTH;
      q = 0;
      for (int b = 7; b >= 0; b--) begin
         t = q | (8'd1 << b);
         if (t <= NORMAL_LENGTH && sum_sq * t * t <= rhs) q = t;
      end
      return (c < 0) ? -norm_type'(q) : norm_type'(q);
   endfunction

   function automatic normal_type face_normal(tri_req_type r);
      logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz;
      logic [127:0]       sum_sq;
      normal_type         n;
      ax = r.v[3] - r.v[0]; ay = r.v[4] - r.v[1]; az = r.v[5] - r.v[2];
      bx = r.v[6] - r.v[0]; by = r.v[7] - r.v[1]; bz = r.v[8] - r.v[2];
      cx = ay * bz - az * by;
      cy = az * bx - ax * bz;
      cz = ax * by - ay * bx;
      n.deg = (cx == 0 && cy == 0 && cz == 0);
      if (n.deg) begin
         n.nx = 0; n.ny = 0; n.nz = 0;
         return n;
      end
      // squares reach 2^66, so widen before multiplying
      sum_sq = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
      n.nx = scaled_component(cx, sum_sq);
      n.ny = scaled_component(cy, sum_sq);
      n.nz = scaled_component(cz, sum_sq);
      return n;
   endfunction

   // directed rows; typed expectation used where known is set
   typedef struct {
      tri_req_type tri_in;
      logic        known;
      normal_type  result;
   } directed_row_type;

   function automatic directed_row_type row(int a0, int a1, int a2, int b0, int b1, int b2,
                                            int c0, int c1, int c2, logic known = 0,
                                            int nx = 0, int ny = 0, int nz = 0,
                                            logic deg = 0);
      directed_row_type d;
      d.tri_in.v = '{coord_type'(a0), coord_type'(a1), coord_type'(a2), coord_type'(b0),
                     coord_type'(b1), coord_type'(b2), coord_type'(c0), coord_type'(c1),
                     coord_type'(c2)};
      d.known = known;
      d.result = '{norm_type'(nx), norm_type'(ny), norm_type'(nz), deg};
      return d;
   endfunction

   directed_row_type directed_rows [$];

   initial begin
      directed_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
      directed_rows.push_back(row(5, 5, 5, 5, 5, 5, 9, 9, 9, 1, 0, 0, 0, 1));
      directed_rows.push_back(row(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 0, 0, 0, 1));
      directed_rows.push_back(row(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0, 127, 0));
      directed_rows.push_back(row(0, 0, 0, 0, 1, 0, 1, 0, 0, 1, 0, 0, -127, 0));
      directed_rows.push_back(row(0, 0, 0, 0, 1, 0, 0, 0, 1, 1, 127, 0, 0, 0));
      directed_rows.push_back(row(0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0, 127, 0, 0));
      directed_rows.push_back(row(-32768, -32768, -32768, 32767, -32768, -32768,
                                  -32768, 32767, -32768));
      directed_rows.push_back(row(32767, 32767, 32767, -32768, 32767, 32767,
                                  32767, -32768, 32767));
      directed_rows.push_back(row(-32768, 32767, -32768, 32767, -32768, 32767,
                                  32767, 32767, -32768));
      directed_rows.push_back(row(32767, -32768, 32767, -32768, 32767, -32768,
                                  -32768, -32768, 32767));
      directed_rows.push_back(row(-32768, -32768, -32768, 32767, 32767, 32767,
                                  -32768, -32768, -32768, 1, 0, 0, 0, 1));
      directed_rows.push_back(row(0, 0, 0, 1, 1, 0, 1, 0, 1));
      directed_rows.push_back(row(0, 0, 0, 3, 0, 0, 0, 4, 12));
      directed_rows.push_back(row(-1, -1, -1, 0, 0, 0, 1, 2, 3));
      directed_rows.push_back(row(100, 200, 300, 101, 200, 300, 100, 200, 300000 % 32768));
      directed_rows.push_back(row(0, 0, 0, 32767, 1, 0, 1, 32767, 0));
   end

   function automatic coord_type random_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom_range(0, 1) ? 32767 : -32768);
         1: return coord_type'($urandom_range(0, 8)) - 4;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic tri_req_type random_triangle();
      tri_req_type r;
      int          k;
      for (int i = 0; i < 9; i++) r.v[i] = random_coord();
      case ($urandom_range(0, 9))
         0: begin
            // collinear: v2 = v0 + k*(v1 - v0) with small values
            k = $urandom_range(0, 4) - 2;
            for (int i = 0; i < 3; i++) begin
               r.v[i] = coord_type'($urandom_range(0, 2000)) - 1000;
               r.v[3+i] = coord_type'($urandom_range(0, 2000)) - 1000;
               r.v[6+i] = coord_type'(r.v[i] + k * (r.v[3+i] - r.v[i]));
            end
         end
         1: for (int i = 0; i < 3; i++) r.v[3+i] = r.v[i];
         2: for (int i = 3; i < 9; i++)
               r.v[i] = r.v[i%3] + coord_type'($urandom_range(0, 6)) - 3;
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_request(tri_req_type r, logic allow_idle);
      int gap;
      if (allow_idle && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      for (int i = 0; i < 9; i++) req_v[i] <= r.v[i];
      @(posedge clock);
      while (busy) @(posedge clock);
      normal_queue.push_back(face_normal(r));
   endtask

   initial begin
      directed_row_type d;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         d = directed_rows[i];
         if (d.known && face_normal(d.tri_in) != d.result)
            $display("%0t: table row %0d disagrees with predictor", $time, i);
         send_request(d.tri_in, 1'b1);
         if (d.known) normal_queue[$] = d.result;
      end
      for (int n = 0; n < RANDOM_ITEMS; n++)
         send_request(random_triangle(), n < RANDOM_ITEMS - 150);
      start <= 1'b0;
      stim_done <= 1'b1;
   end

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      normal_type e;
      if (!reset && rsp_valid) begin
         checked++;
         if (rsp_degenerate) degenerate_seen++;
         if (normal_queue.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none actual %0d %0d %0d %0b",
                     $time, rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_degenerate);
         end else begin
            e = normal_queue.pop_front();
            check_field("norm_x", e.nx, rsp_norm_x);
            check_field("norm_y", e.ny, rsp_norm_y);
            check_field("norm_z", e.nz, rsp_norm_z);
            check_field("degenerate", e.deg, rsp_degenerate);
         end
      end
   end

   // count cycles in which neither a request nor a result moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (stim_done === 1'b1);
      while (normal_queue.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      if (normal_queue.size() == 0) repeat (PIPE_DRAIN) @(posedge clock);
      $display("Checked %0d results, %0d of them degenerate triangles,", checked,
               degenerate_seen);
      $display("from directed extremes and random full-range and collinear requests.");
      if (normal_queue.size() != 0) begin
         $display("Timeout with %0d results outstanding", normal_queue.size());
         $display("Test completed with failures");
      end else if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT && stim_done !== 1'b1);
      $display("Watchdog expired at %0t", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
